/* src/mfe_pkg.sv */
// Shared types, constants and the CRC-8 DVB-S2 byte update for the MSP v2 frame encoder.
// Depends on nothing; the cfg interface, the top level, front, queue and back refer to it by scoped names.
package mfe_pkg;

    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] CRC_TOPBIT  = 8'h80;
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_X      = 8'h58;
    localparam logic [7:0] SYNC_REQ    = 8'h3C;

    localparam logic [15:0] FUNCTION_ID_RESET    = 16'h1F03;
    localparam logic [7:0]  FRAME_FLAGS_RESET    = 8'h00;
    localparam logic [15:0] PAYLOAD_LENGTH_RESET = 16'd41;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FUNCTION_ID    = 2'd0,
        CFG_FRAME_FLAGS    = 2'd1,
        CFG_PAYLOAD_LENGTH = 2'd2
    } cfg_index_t;

    // Position of one link byte inside a frame.
    typedef enum logic [3:0] {
        BYTE_SYNC_DOLLAR = 4'd0,
        BYTE_SYNC_X      = 4'd1,
        BYTE_SYNC_REQ    = 4'd2,
        BYTE_FLAGS       = 4'd3,
        BYTE_ID_LO       = 4'd4,
        BYTE_ID_HI       = 4'd5,
        BYTE_LEN_LO      = 4'd6,
        BYTE_LEN_HI      = 4'd7,
        BYTE_DATA        = 4'd8,
        BYTE_CRC         = 4'd9
    } byte_kind_t;

    // One classified payload byte with the header it opens, if it opens one.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        frame_first;
        logic [7:0]  frame_flags;
        logic [15:0] function_id;
        logic [15:0] payload_length;
    } entry_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if ((v & CRC_TOPBIT) != 8'h00)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

endpackage

/* src/mfe_payload_if.sv */
// Payload byte channel of the MSP v2 frame encoder: valid, ready and one byte with its last mark.
// Stands alone; no package needed.
interface mfe_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_last;

    modport source (output valid, output payload_byte, output payload_last, input ready);
    modport sink (input valid, input payload_byte, input payload_last, output ready);
endinterface

/* src/mfe_link_if.sv */
// Link byte channel of the MSP v2 frame encoder: valid, ready and one framed byte.
// Stands alone; no package needed.
interface mfe_link_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       frame_done;

    modport source (output valid, output wire_byte, output frame_done, input ready);
    modport sink (input valid, input wire_byte, input frame_done, output ready);
endinterface

/* src/mfe_cfg_if.sv */
// Register write channel of the MSP v2 frame encoder: valid, ready, index and data.
// Uses mfe_pkg for the index and data widths.
interface mfe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mfe_pkg::CFG_INDEX_W-1:0] index;
    logic [mfe_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/msp_v2_frame_encoder_unit.sv */
// Top level of the MSP v2 request frame encoder with CRC-8 DVB-S2 checksum.
// Uses mfe_pkg, the three channel interfaces, mfe_front, mfe_queue and mfe_back.
//
//   Channel   Direction  Contents                          Transaction
//   payload   in         payload_byte[7:0], payload_last   one payload byte
//   link      out        wire_byte[7:0], frame_done        one framed link byte
//   cfg       in         index[1:0], data[15:0]            one register write
//
// The link side sends one byte per cycle while the queue holds an entry and the link is ready:
// a payload byte gives one link byte, plus eight header bytes when it opens a frame and
// one checksum byte when it closes one. An accepted payload byte is written into the queue,
// and its link bytes are taken from the queue head into the registered link outputs.
// The front accepts a byte per cycle while the queue has room, so either side may stall alone.
// Reset restores the register defaults and starts outside a frame; no clearing pass.
module msp_v2_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    mfe_payload_if.sink payload,
    mfe_link_if.source  link,
    mfe_cfg_if.sink     cfg
);

    logic            push_valid;
    logic            push_ready;
    mfe_pkg::entry_t push_entry;
    logic            head_valid;
    mfe_pkg::entry_t head_entry;
    logic            pop;

    mfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    mfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    mfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .link       (link)
    );

endmodule

/* src/mfe_front.sv */
// Front end of the frame encoder: configuration registers, frame tracking and byte classification.
// Uses mfe_pkg, mfe_payload_if and mfe_cfg_if.
module mfe_front (
    input  logic               clk,
    input  logic               rst_n,
    mfe_payload_if.sink        payload,
    mfe_cfg_if.sink            cfg,
    output logic               push_valid,
    output mfe_pkg::entry_t    push_entry,
    input  logic               push_ready
);

    logic [15:0] function_id_reg;
    logic [7:0]  frame_flags_reg;
    logic [15:0] payload_length_reg;
    logic        inside_frame_reg;
    logic        inside_frame_next;
    logic        accept;

    assign cfg.ready     = 1'b1;
    assign payload.ready = push_ready;
    assign push_valid    = payload.valid;
    assign accept        = payload.valid & push_ready;

    // The header fields travel with the byte that opens the frame.
    always_comb
    begin
        push_entry.payload_byte   = payload.payload_byte;
        push_entry.payload_last   = payload.payload_last;
        push_entry.frame_first    = ~inside_frame_reg;
        push_entry.frame_flags    = frame_flags_reg;
        push_entry.function_id    = function_id_reg;
        push_entry.payload_length = payload_length_reg;
    end

    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        if (accept)
        begin
            inside_frame_next = ~payload.payload_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_id_reg    <= mfe_pkg::FUNCTION_ID_RESET;
            frame_flags_reg    <= mfe_pkg::FRAME_FLAGS_RESET;
            payload_length_reg <= mfe_pkg::PAYLOAD_LENGTH_RESET;
            inside_frame_reg   <= 1'b0;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
            if (cfg.valid)
            begin
                case (mfe_pkg::cfg_index_t'(cfg.index))
                    mfe_pkg::CFG_FUNCTION_ID:    function_id_reg    <= cfg.data;
                    mfe_pkg::CFG_FRAME_FLAGS:    frame_flags_reg    <= cfg.data[7:0];
                    mfe_pkg::CFG_PAYLOAD_LENGTH: payload_length_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

/* src/mfe_queue.sv */
// Small register queue between the front and back ends of the frame encoder.
// Uses mfe_pkg for the entry type.
module mfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  mfe_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            head_valid,
    output mfe_pkg::entry_t head_entry,
    input  logic            pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfe_pkg::entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/mfe_back.sv */
// Back end of the frame encoder: emits header, payload and checksum bytes one per cycle unless stalled.
// Uses mfe_pkg and mfe_link_if; takes its work from mfe_queue.
module mfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mfe_pkg::entry_t head_entry,
    output logic            pop,
    mfe_link_if.source      link
);

    logic [3:0]          step_reg;
    logic [3:0]          step_next;
    logic [7:0]          crc_reg;
    logic [7:0]          crc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          wire_byte_reg;
    logic [7:0]          wire_byte_next;
    logic                frame_done_reg;
    logic                frame_done_next;
    logic                load;
    logic                entry_end;
    mfe_pkg::byte_kind_t kind;
    logic [7:0]          sel_byte;

    assign link.valid      = out_valid_reg;
    assign link.wire_byte  = wire_byte_reg;
    assign link.frame_done = frame_done_reg;

    // A byte that continues a frame skips the eight header positions.
    assign kind = mfe_pkg::byte_kind_t'(head_entry.frame_first ? step_reg : step_reg + 4'd8);
    assign load = head_valid & (~out_valid_reg | link.ready);
    assign entry_end = head_entry.payload_last ? (kind == mfe_pkg::BYTE_CRC)
                                               : (kind == mfe_pkg::BYTE_DATA);
    assign pop = load & entry_end;

    always_comb
    begin
        case (kind)
            mfe_pkg::BYTE_SYNC_DOLLAR: sel_byte = mfe_pkg::SYNC_DOLLAR;
            mfe_pkg::BYTE_SYNC_X:      sel_byte = mfe_pkg::SYNC_X;
            mfe_pkg::BYTE_SYNC_REQ:    sel_byte = mfe_pkg::SYNC_REQ;
            mfe_pkg::BYTE_FLAGS:       sel_byte = head_entry.frame_flags;
            mfe_pkg::BYTE_ID_LO:       sel_byte = head_entry.function_id[7:0];
            mfe_pkg::BYTE_ID_HI:       sel_byte = head_entry.function_id[15:8];
            mfe_pkg::BYTE_LEN_LO:      sel_byte = head_entry.payload_length[7:0];
            mfe_pkg::BYTE_LEN_HI:      sel_byte = head_entry.payload_length[15:8];
            mfe_pkg::BYTE_DATA:        sel_byte = head_entry.payload_byte;
            mfe_pkg::BYTE_CRC:         sel_byte = crc_reg;
            default:                   sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        step_next       = step_reg;
        crc_next        = crc_reg;
        out_valid_next  = out_valid_reg & ~link.ready;
        wire_byte_next  = wire_byte_reg;
        frame_done_next = frame_done_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            wire_byte_next  = sel_byte;
            frame_done_next = (kind == mfe_pkg::BYTE_CRC);
            step_next       = entry_end ? 4'd0 : step_reg + 4'd1;
            if (kind inside {mfe_pkg::BYTE_FLAGS, mfe_pkg::BYTE_ID_LO, mfe_pkg::BYTE_ID_HI,
                             mfe_pkg::BYTE_LEN_LO, mfe_pkg::BYTE_LEN_HI, mfe_pkg::BYTE_DATA})
            begin
                crc_next = mfe_pkg::crc8_byte(crc_reg, sel_byte);
            end
            else
            begin
                // Sync bytes open a frame and the checksum byte closes one.
                crc_next = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            crc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wire_byte_reg  <= wire_byte_next;
        frame_done_reg <= frame_done_next;
    end

endmodule

/* tb/tb_msp_v2_frame_encoder_unit.sv */
// Self-checking testbench for msp_v2_frame_encoder_unit: payload bytes in, framed link bytes out.
// Depends on mfe_pkg, the payload, link and cfg channel interfaces, and the encoder RTL.
// A frame model predicts every link byte and its close flag; the bench drives all three channels.
module tb_msp_v2_frame_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int ERRORS_SHOWN = 10;
    // Index 3 has no register behind it, so writes to it must change nothing.
    localparam logic [mfe_pkg::CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_done;
    } link_beat_t;

    class frame_encoder_model;
        logic [15:0] function_id;
        logic [7:0]  frame_flags;
        logic [15:0] payload_length;
        bit          in_frame;
        logic [7:0]  checksum;
        link_beat_t  expected_link_bytes[$];
        int          errors;
        int          bytes_checked;
        int          payload_bytes;
        int          frames_closed;

        function new();
            function_id    = mfe_pkg::FUNCTION_ID_RESET;
            frame_flags    = mfe_pkg::FRAME_FLAGS_RESET;
            payload_length = mfe_pkg::PAYLOAD_LENGTH_RESET;
            in_frame       = 1'b0;
            checksum       = 8'h00;
            errors         = 0;
            bytes_checked  = 0;
            payload_bytes  = 0;
            frames_closed  = 0;
        endfunction

        function void write_reg(input logic [mfe_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [mfe_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                mfe_pkg::CFG_FUNCTION_ID:    function_id = value;
                mfe_pkg::CFG_FRAME_FLAGS:    frame_flags = value[7:0];
                mfe_pkg::CFG_PAYLOAD_LENGTH: payload_length = value;
                default: ;
            endcase
        endfunction

        // Bit-serial form of the DVB-S2 CRC, data fed most significant bit first.
        function logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
            logic [7:0] r;
            logic       fb;
            r = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = r[7] ^ data[i];
                r = {r[6:0], 1'b0} ^ (fb ? mfe_pkg::CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void push_beat(input logic [7:0] b, input logic done);
            link_beat_t beat;
            beat.wire_byte  = b;
            beat.frame_done = done;
            expected_link_bytes.push_back(beat);
        endfunction

        function void take_payload(input logic [7:0] data, input logic last);
            logic [7:0] header[5];
            payload_bytes++;
            if (!in_frame) begin
                header = '{frame_flags, function_id[7:0], function_id[15:8],
                           payload_length[7:0], payload_length[15:8]};
                push_beat(mfe_pkg::SYNC_DOLLAR, 1'b0);
                push_beat(mfe_pkg::SYNC_X, 1'b0);
                push_beat(mfe_pkg::SYNC_REQ, 1'b0);
                checksum = 8'h00;
                foreach (header[i]) begin
                    push_beat(header[i], 1'b0);
                    checksum = crc_update(checksum, header[i]);
                end
                in_frame = 1'b1;
            end
            push_beat(data, 1'b0);
            checksum = crc_update(checksum, data);
            if (last) begin
                push_beat(checksum, 1'b1);
                checksum = 8'h00;
                in_frame = 1'b0;
                frames_closed++;
            end
        endfunction

        function void check_link_byte(input logic [7:0] wire_byte, input logic frame_done);
            link_beat_t want;
            bytes_checked++;
            if (expected_link_bytes.size() == 0) begin
                errors++;
                if (errors <= ERRORS_SHOWN)
                    $display("ERROR: link byte %0d with nothing pending: byte %02h done %0b",
                             bytes_checked, wire_byte, frame_done);
                return;
            end
            want = expected_link_bytes.pop_front();
            if (want.wire_byte !== wire_byte || want.frame_done !== frame_done) begin
                errors++;
                if (errors <= ERRORS_SHOWN)
                    $display({"ERROR: link byte %0d: expected byte %02h done %0b, ",
                              "got byte %02h done %0b"},
                             bytes_checked, want.wire_byte, want.frame_done,
                             wire_byte, frame_done);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   link_stall_pct;
    int   reg_writes;
    int   cycle_count;
    int   sender_idle_by_phase[4] = '{0, 82, 0, 21};
    int   link_stall_by_phase[4]  = '{0, 0, 82, 21};
    frame_encoder_model model;

    mfe_payload_if payload_ch();
    mfe_link_if    link_ch();
    mfe_cfg_if     cfg_ch();

    msp_v2_frame_encoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload_ch),
        .link    (link_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        link_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            link_ch.ready <= ($urandom_range(99) >= link_stall_pct);
        end
    end

    // Both channels are sampled on the edge itself; every driver updates after it.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (payload_ch.valid && payload_ch.ready)
                model.take_payload(payload_ch.payload_byte, payload_ch.payload_last);
            if (link_ch.valid && link_ch.ready)
                model.check_link_byte(link_ch.wire_byte, link_ch.frame_done);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d link bytes still pending.",
                 model.expected_link_bytes.size());
        $display("Mismatches found");
        $finish;
    end

    // Valid stays high across back-to-back transactions; it drops only while the sender idles.
    task automatic send_payload(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            payload_ch.valid <= 1'b0;
            @(posedge clk);
        end
        payload_ch.valid        <= 1'b1;
        payload_ch.payload_byte <= data;
        payload_ch.payload_last <= last;
        do @(posedge clk); while (payload_ch.ready !== 1'b1);
    endtask

    task automatic drain_link();
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.expected_link_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [mfe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mfe_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        model.write_reg(idx, value);
        reg_writes++;
    endtask

    // Biased toward the range ends; bits above the register width are random noise.
    function automatic logic [15:0] pick_reg_value(input logic [15:0] max_value);
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return 16'h0000 | (16'($urandom) & ~max_value);
        else if (r < 40)
            return max_value | (16'($urandom) & ~max_value);
        return 16'($urandom);
    endfunction

    task automatic load_registers();
        cfg_write(mfe_pkg::CFG_FUNCTION_ID, pick_reg_value(16'hFFFF));
        cfg_write(mfe_pkg::CFG_FRAME_FLAGS, pick_reg_value(16'h00FF));
        cfg_write(mfe_pkg::CFG_PAYLOAD_LENGTH, pick_reg_value(16'hFFFF));
        if ($urandom_range(1) == 1)
            cfg_write(CFG_INDEX_UNUSED, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Frames of random size; a few are left open so the next phase's writes land mid-frame.
    task automatic run_random_frames(input int target);
        int sent;
        int len;
        int r;
        int pause_at;
        bit close;
        logic [7:0] data;
        sent = 0;
        pause_at = $urandom_range(target / 4, 3 * target / 4);
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (r < 8)
                len = 41;
            else if (r < 20)
                len = 1;
            else
                len = $urandom_range(2, 12);
            close = ($urandom_range(15) != 0);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < 10)
                    data = 8'h00;
                else if (r < 20)
                    data = 8'hFF;
                else
                    data = 8'($urandom);
                send_payload(data, close && (i == len - 1));
                sent++;
            end
            if (sent >= pause_at)
            begin
                drain_link();
                pause_at = target + 1;
            end
        end
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        payload_ch.valid        <= 1'b0;
        payload_ch.payload_byte <= 8'h00;
        payload_ch.payload_last <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= mfe_pkg::CFG_FUNCTION_ID;
        cfg_ch.data             <= 16'h0000;
        sender_idle_pct = 0;
        link_stall_pct  = 0;
        reg_writes      = 0;
        model = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: a one-byte frame, then a short frame.
        send_payload(8'h00, 1'b1);
        send_payload(8'hFF, 1'b0);
        send_payload(8'h80, 1'b0);
        send_payload(8'h01, 1'b1);

        // All registers at their maximum, plus a write to the unused index.
        drain_link();
        cfg_write(mfe_pkg::CFG_FUNCTION_ID, 16'hFFFF);
        cfg_write(mfe_pkg::CFG_FRAME_FLAGS, 16'hFFFF);
        cfg_write(mfe_pkg::CFG_PAYLOAD_LENGTH, 16'hFFFF);
        cfg_write(CFG_INDEX_UNUSED, 16'hA5C3);
        cfg_ch.valid <= 1'b0;
        send_payload(8'hAA, 1'b0);
        send_payload(8'h55, 1'b1);

        drain_link();
        cfg_write(mfe_pkg::CFG_FUNCTION_ID, 16'h0000);
        cfg_write(mfe_pkg::CFG_FRAME_FLAGS, 16'h0000);
        cfg_write(mfe_pkg::CFG_PAYLOAD_LENGTH, 16'h0000);
        cfg_write(CFG_INDEX_UNUSED, 16'h0000);
        cfg_ch.valid <= 1'b0;
        send_payload(8'h7F, 1'b1);

        // The header length says two bytes but four are sent, and the registers change
        // while the frame is open; only the following frame may see the new values.
        drain_link();
        cfg_write(mfe_pkg::CFG_PAYLOAD_LENGTH, 16'd2);
        cfg_ch.valid <= 1'b0;
        send_payload(8'h12, 1'b0);
        drain_link();
        cfg_write(mfe_pkg::CFG_FRAME_FLAGS, 16'h005A);
        cfg_write(mfe_pkg::CFG_FUNCTION_ID, 16'h1234);
        cfg_ch.valid <= 1'b0;
        send_payload(8'h34, 1'b0);
        send_payload(8'h56, 1'b0);
        send_payload(8'h78, 1'b1);
        send_payload(8'h9A, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            drain_link();
            sender_idle_pct = sender_idle_by_phase[p];
            link_stall_pct  = link_stall_by_phase[p];
            load_registers();
            run_random_frames(ITEMS_PER_PHASE);
        end

        drain_link();
        repeat (10) @(posedge clk);

        $display("Covered %0d payload bytes in %0d closed frames under four pressure mixes,",
                 model.payload_bytes, model.frames_closed);
        $display("with %0d register writes and %0d link bytes compared.",
                 reg_writes, model.bytes_checked);
        if (model.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
